@@ hw/rtl/trst_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trst_pkg
// shared constants and types of the transmit rate statistics table
// ----------------------------------------------------------------------------
package trst_pkg;

	localparam int MaxPeers  = 8;
	localparam int NumRates  = 128;
	localparam int SlotW     = 3;
	localparam int RateW     = 7;
	localparam int CellW     = SlotW + RateW;
	localparam int Cells     = MaxPeers * NumRates;
	localparam int CntW      = 32;

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_STATUS = 2'd2,
		MODE_TICK   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_UNKNOWN = 2'd1,
		ST_FULL    = 2'd2,
		ST_PRESENT = 2'd3
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;    // capture the input transaction
		logic exec;    // execute state: counter memory read data is ready
		logic clear;   // zero the counters of a newly added slot, one rate per cycle
	} cmd_t;

endpackage : trst_pkg
`default_nettype wire

@@ hw/rtl/trst_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trst_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module trst_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule : trst_ram
`default_nettype wire

@@ hw/rtl/trst_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trst_ctrl
// sequencer: capture, execute, then a clearing pass after a successful add
// ----------------------------------------------------------------------------
module trst_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          alloc,
	input  wire logic          clr_last,
	output logic               busy,
	output trst_pkg::cmd_t     cmd
);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_CLEAR} state_t;
	state_t state_q;

	assign busy = (state_q != S_IDLE);
	assign cmd  = '{load:  start && (state_q == S_IDLE),
			exec:  (state_q == S_EXEC),
			clear: (state_q == S_CLEAR)};

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_EXEC;
				S_EXEC: state_q <= alloc ? S_CLEAR : S_IDLE;
				S_CLEAR: if (clr_last) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule : trst_ctrl
`default_nettype wire

@@ hw/rtl/trst_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trst_dp
// peer table, counter memories, clearing pass and result register
// ----------------------------------------------------------------------------
module trst_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire trst_pkg::cmd_t cmd,
	input  wire logic [1:0]     mode,
	input  wire logic [47:0]    station_addr,
	input  wire logic           entry_valid,
	input  wire logic [6:0]     rate_index,
	input  wire logic [7:0]     attempt_count,
	input  wire logic           report_success,
	input  wire logic           last_entry,
	output logic                alloc,
	output logic                clr_last,
	output logic                done,
	output logic [1:0]          status,
	output logic [2:0]          peer_slot,
	output logic [31:0]         attempts_total,
	output logic [31:0]         success_total,
	output logic [3:0]          updated_peers
);

	localparam int P = trst_pkg::MaxPeers;
	localparam int SW = trst_pkg::SlotW;
	localparam int RW = trst_pkg::RateW;
	localparam int CW = trst_pkg::CellW;
	localparam int N = trst_pkg::CntW;

	logic [47:0]  addr_q [P];
	logic [P-1:0] use_q, upd_q;
	logic [RW-1:0] last_rate_q;
	logic          last_known_q, ended_q;
	logic [RW-1:0] clr_q;

	// captured transaction
	logic [1:0]    mode_q;
	logic          hit_q, free_q, ent_q, suc_q, lst_q, lrk_q;
	logic [SW-1:0] hslot_q, fslot_q;
	logic [7:0]    att_q;
	logic [47:0]   paddr_q;

	// peer search
	logic          hit, free;
	logic [SW-1:0] hslot, fslot;
	always_comb begin
		hit = 1'b0; free = 1'b0; hslot = '0; fslot = '0;
		for (int s = P - 1; s >= 0; s--) begin
			if (use_q[s] && addr_q[s] == station_addr) begin
				hit = 1'b1; hslot = SW'(s);
			end
			if (!use_q[s]) begin
				free = 1'b1; fslot = SW'(s);
			end
		end
	end

	// which rate the entry acts on: attempt rate or success rate
	logic do_att, do_suc;
	logic [RW-1:0] cell_rate;
	assign do_att = !ended_q && entry_valid;
	assign do_suc = last_entry && report_success && (do_att || last_known_q);
	assign cell_rate = do_att ? rate_index : last_rate_q;

	logic [CW-1:0] raddr, cell_q;
	assign raddr = {hslot, cell_rate};

	logic [N-1:0]  att_rd, suc_rd;
	logic          we;
	logic [CW-1:0] waddr;
	logic [N-1:0]  att_wd, suc_wd;
	logic [N-1:0]  att_wr, suc_wr;
	logic          act_att, act_suc;

	assign act_att = hit_q && mode_q == trst_pkg::MODE_STATUS && ent_q;
	assign act_suc = hit_q && mode_q == trst_pkg::MODE_STATUS && lst_q && suc_q && lrk_q;

	// status to the controller
	assign alloc    = mode_q == trst_pkg::MODE_ADD && !hit_q && free_q;
	assign clr_last = &clr_q;

	// saturating updates
	always_comb begin
		logic [N:0] a_sum;
		a_sum  = {1'b0, att_rd} + {{(N - 7){1'b0}}, att_q};
		att_wd = att_rd;
		suc_wd = suc_rd;
		if (act_att) att_wd = a_sum[N] ? '1 : a_sum[N-1:0];
		if (act_suc) suc_wd = (&suc_rd) ? suc_rd : suc_rd + 1'b1;
	end

	// write port: counter update, or zeroing of a new slot
	assign we     = (cmd.exec && (act_att || act_suc)) || cmd.clear;
	assign waddr  = cmd.clear ? {fslot_q, clr_q} : cell_q;
	assign att_wr = cmd.clear ? '0 : att_wd;
	assign suc_wr = cmd.clear ? '0 : suc_wd;

	trst_ram #(.Width(N), .Depth(trst_pkg::Cells)) u_att (
		.clk(clk), .we(we), .waddr(waddr), .wdata(att_wr), .raddr(raddr), .rdata(att_rd)
	);
	trst_ram #(.Width(N), .Depth(trst_pkg::Cells)) u_suc (
		.clk(clk), .we(we), .waddr(waddr), .wdata(suc_wr), .raddr(raddr), .rdata(suc_rd)
	);

	// clearing pass index over the rates of a new slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + RW'(1);
		end
	end

	// capture stage
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			hit_q   <= hit;
			free_q  <= free;
			hslot_q <= hslot;
			fslot_q <= fslot;
			ent_q   <= do_att;
			suc_q   <= report_success;
			lst_q   <= last_entry;
			lrk_q   <= do_suc;
			att_q   <= attempt_count;
			paddr_q <= station_addr;
			cell_q  <= raddr;
		end
	end

	// peer table
	always_ff @(posedge clk) begin
		if (cmd.exec && mode_q == trst_pkg::MODE_ADD && !hit_q && free_q)
			addr_q[fslot_q] <= paddr_q;
	end

	// control state: peer flags, report tracking, result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_q <= '0; upd_q <= '0;
			last_rate_q <= '0; last_known_q <= 1'b0; ended_q <= 1'b0;
			done <= 1'b0;
			status <= '0; peer_slot <= '0; attempts_total <= '0;
			success_total <= '0; updated_peers <= '0;
		end else begin
			done <= cmd.exec;
			if (cmd.load && mode == trst_pkg::MODE_STATUS) begin
				if (hit && !ended_q) begin
					if (!entry_valid) ended_q <= 1'b1;
					else begin
						last_rate_q  <= rate_index;
						last_known_q <= 1'b1;
					end
				end
				if (last_entry) begin
					last_rate_q <= '0; last_known_q <= 1'b0; ended_q <= 1'b0;
				end
			end
			if (cmd.exec) begin
				status <= trst_pkg::ST_OK; peer_slot <= '0;
				attempts_total <= '0; success_total <= '0; updated_peers <= '0;
				unique case (trst_pkg::mode_t'(mode_q))
					trst_pkg::MODE_ADD: begin
						if (hit_q) begin
							status <= trst_pkg::ST_PRESENT; peer_slot <= hslot_q;
						end else if (!free_q) begin
							status <= trst_pkg::ST_FULL;
						end else begin
							use_q[fslot_q] <= 1'b1;
							upd_q[fslot_q] <= 1'b0;
							peer_slot <= fslot_q;
						end
					end
					trst_pkg::MODE_REMOVE: begin
						if (!hit_q) status <= trst_pkg::ST_UNKNOWN;
						else begin
							use_q[hslot_q] <= 1'b0;
							upd_q[hslot_q] <= 1'b0;
							peer_slot <= hslot_q;
						end
					end
					trst_pkg::MODE_STATUS: begin
						if (!hit_q) status <= trst_pkg::ST_UNKNOWN;
						else begin
							peer_slot <= hslot_q;
							if (lst_q) upd_q[hslot_q] <= 1'b1;
							if (act_att || act_suc) begin
								attempts_total <= att_wd;
								success_total  <= suc_wd;
							end
						end
					end
					trst_pkg::MODE_TICK: begin
						updated_peers <= 4'($countones(use_q & upd_q));
						upd_q <= '0;
					end
					default: status <= trst_pkg::ST_OK;
				endcase
			end
		end
	end

endmodule : trst_dp
`default_nettype wire

@@ hw/rtl/tx_rate_stats_table_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tx_rate_stats_table_top
// per-station transmit statistics table for rate control
// ----------------------------------------------------------------------------
// result strobe done is registered from the execute state that follows the accepting edge
// a new transaction is accepted only once busy has fallen; the counter memory
//   read-modify-write reads at the capture edge and writes in the execute state
// a successful add keeps busy high through a clearing pass that zeroes the slot's counters
// reset clears peer table flags and report tracking; counters are zeroed on add
// ----------------------------------------------------------------------------
module tx_rate_stats_table_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  mode,
	input  wire logic [47:0] station_addr,
	input  wire logic        entry_valid,
	input  wire logic [6:0]  rate_index,
	input  wire logic [7:0]  attempt_count,
	input  wire logic        report_success,
	input  wire logic        last_entry,
	output logic             done,
	output logic [1:0]       status,
	output logic [2:0]       peer_slot,
	output logic [31:0]      attempts_total,
	output logic [31:0]      success_total,
	output logic [3:0]       updated_peers
);

	trst_pkg::cmd_t cmd;
	logic           alloc;
	logic           clr_last;

	trst_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .alloc(alloc), .clr_last(clr_last),
		.busy(busy), .cmd(cmd)
	);

	trst_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .mode(mode), .station_addr(station_addr),
		.entry_valid(entry_valid), .rate_index(rate_index), .attempt_count(attempt_count),
		.report_success(report_success), .last_entry(last_entry), .alloc(alloc),
		.clr_last(clr_last), .done(done),
		.status(status), .peer_slot(peer_slot), .attempts_total(attempts_total),
		.success_total(success_total), .updated_peers(updated_peers)
	);

endmodule : tx_rate_stats_table_top
`default_nettype wire

@@ hw/rtl/trst_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trst_checker
// port level checks of the statistics table
// ----------------------------------------------------------------------------
module trst_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [1:0]  status,
	input wire logic [3:0]  updated_peers
);

	// accepted transaction raises busy next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy missing");

	// result strobe follows acceptance, after the execute state
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done) else $error("result missing");

	// no result without a preceding busy cycle
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("spurious result");

	// peer count never exceeds the table size
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> updated_peers <= 4'(trst_pkg::MaxPeers)) else $error("count range");

	// a peer count only comes with an ok tick
	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		done && updated_peers != 4'd0 |-> status == trst_pkg::ST_OK)
		else $error("count with bad status");

endmodule : trst_checker

bind tx_rate_stats_table_top trst_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .updated_peers(updated_peers)
);
`default_nettype wire

@@ tb/sv/tx_rate_stats_table_top_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tx_rate_stats_table_top_tb
// self-checking testbench of the transmit rate statistics table: a queue-fed
// driver issues add, remove, status and tick transactions, a scoreboard model
// of the peer table and rate counters predicts each result, and a monitor
// compares every strobed result field by field with the oldest prediction
// ----------------------------------------------------------------------------
module tx_rate_stats_table_top_tb;

	import trst_pkg::*;

	localparam int NumItems  = 1750;
	localparam int PoolSize  = 12;
	localparam logic [CntW-1:0] CntMax = '1;

	typedef struct {
		mode_t       mode;
		logic [47:0] addr;
		logic        ev;
		logic [6:0]  rate;
		logic [7:0]  att;
		logic        succ;
		logic        last;
		bit          drain;
		int          idle_pct;
	} stim_t;

	typedef struct {
		status_t     st;
		logic [2:0]  slot;
		logic [31:0] att;
		logic [31:0] suc;
		logic [3:0]  upd;
	} stats_res_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  mode;
	logic [47:0] station_addr;
	logic        entry_valid;
	logic [6:0]  rate_index;
	logic [7:0]  attempt_count;
	logic        report_success;
	logic        last_entry;
	logic        done;
	logic [1:0]  status;
	logic [2:0]  peer_slot;
	logic [31:0] attempts_total;
	logic [31:0] success_total;
	logic [3:0]  updated_peers;

	stim_t      pending_q[$];
	stats_res_t expected_q[$];
	bit         taken;
	bit         failed;
	int         cur_idle;
	logic [47:0] addr_pool[PoolSize];

	// scoreboard copy of the table
	logic [47:0]     sb_addr[MaxPeers];
	bit              sb_in_use[MaxPeers];
	bit              sb_has_upd[MaxPeers];
	bit              sb_rate_valid[Cells];
	logic [CntW-1:0] sb_att[Cells];
	logic [CntW-1:0] sb_suc[Cells];
	logic [6:0]      sb_last_rate;
	bit              sb_last_known;
	bit              sb_ended;

	tx_rate_stats_table_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.station_addr(station_addr), .entry_valid(entry_valid), .rate_index(rate_index),
		.attempt_count(attempt_count), .report_success(report_success),
		.last_entry(last_entry), .done(done), .status(status), .peer_slot(peer_slot),
		.attempts_total(attempts_total), .success_total(success_total),
		.updated_peers(updated_peers)
	);

	function automatic logic [CntW-1:0] sat_add(logic [CntW-1:0] a, logic [CntW-1:0] b);
		return (a > CntMax - b) ? CntMax : a + b;
	endfunction

	function automatic int find_slot(logic [47:0] a);
		for (int s = 0; s < MaxPeers; s++)
			if (sb_in_use[s] && sb_addr[s] == a)
				return s;
		return -1;
	endfunction

	function automatic void open_rate(int c);
		if (!sb_rate_valid[c]) begin
			sb_rate_valid[c] = 1'b1;
			sb_att[c] = '0;
			sb_suc[c] = '0;
		end
	endfunction

	// expected result of one accepted transaction, updates the scoreboard table
	function automatic stats_res_t predict_stats(stim_t t);
		stats_res_t r;
		int s;
		int c;
		int n;
		bit touched;
		r = '{ST_OK, 3'd0, 32'd0, 32'd0, 4'd0};
		s = find_slot(t.addr);
		c = 0;
		touched = 0;
		case (t.mode)
			MODE_ADD: begin
				if (s >= 0) begin
					r.st = ST_PRESENT;
					r.slot = s[2:0];
				end else begin
					s = 0;
					while (s < MaxPeers && sb_in_use[s])
						s++;
					if (s >= MaxPeers) begin
						r.st = ST_FULL;
					end else begin
						sb_in_use[s] = 1'b1;
						sb_addr[s] = t.addr;
						sb_has_upd[s] = 1'b0;
						for (int k = 0; k < NumRates; k++)
							sb_rate_valid[s * NumRates + k] = 1'b0;
						r.slot = s[2:0];
					end
				end
			end
			MODE_REMOVE: begin
				if (s < 0) begin
					r.st = ST_UNKNOWN;
				end else begin
					sb_in_use[s] = 1'b0;
					sb_has_upd[s] = 1'b0;
					r.slot = s[2:0];
				end
			end
			MODE_STATUS: begin
				if (s < 0) begin
					r.st = ST_UNKNOWN;
				end else begin
					r.slot = s[2:0];
					if (!sb_ended) begin
						if (!t.ev) begin
							sb_ended = 1'b1;
						end else begin
							c = s * NumRates + t.rate;
							open_rate(c);
							sb_att[c] = sat_add(sb_att[c], {24'd0, t.att});
							sb_last_rate = t.rate;
							sb_last_known = 1'b1;
							touched = 1;
						end
					end
					if (t.last) begin
						if (t.succ && sb_last_known) begin
							c = s * NumRates + sb_last_rate;
							open_rate(c);
							sb_suc[c] = sat_add(sb_suc[c], 32'd1);
							touched = 1;
						end
						sb_has_upd[s] = 1'b1;
					end
					if (touched) begin
						r.att = sb_att[c];
						r.suc = sb_suc[c];
					end
				end
				if (t.last) begin
					sb_last_rate = '0;
					sb_last_known = 1'b0;
					sb_ended = 1'b0;
				end
			end
			default: begin
				n = 0;
				for (int k = 0; k < MaxPeers; k++) begin
					if (sb_in_use[k] && sb_has_upd[k])
						n++;
					sb_has_upd[k] = 1'b0;
				end
				r.upd = (n > 15) ? 4'd15 : n[3:0];
			end
		endcase
		return r;
	endfunction

	function automatic void add_item(mode_t m, logic [47:0] a, logic ev, logic [6:0] rt,
			logic [7:0] at, logic sc, logic lst);
		pending_q.push_back('{m, a, ev, rt, at, sc, lst, 1'b0, cur_idle});
	endfunction

	function automatic void add_drain();
		stim_t t;
		t = '{MODE_TICK, '0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b1, 0};
		pending_q.push_back(t);
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// reset, asserted at time zero and released on a falling edge
	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// driver: new transaction on the falling edge, held until accepted
	initial begin
		start = 1'b0;
		mode = MODE_ADD;
		station_addr = '0;
		entry_valid = 1'b0;
		rate_index = '0;
		attempt_count = '0;
		report_success = 1'b0;
		last_entry = 1'b0;
		taken = 1'b0;
	end

	always @(negedge clk) begin
		stim_t t;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !taken) begin
			start <= 1'b1;
		end else if (pending_q.size() == 0) begin
			start <= 1'b0;
		end else if (pending_q[0].drain) begin
			if (expected_q.size() == 0)
				void'(pending_q.pop_front());
			start <= 1'b0;
		end else if ($urandom_range(99) < pending_q[0].idle_pct) begin
			start <= 1'b0;
		end else begin
			t = pending_q.pop_front();
			taken = 1'b0;
			start <= 1'b1;
			mode <= t.mode;
			station_addr <= t.addr;
			entry_valid <= t.ev;
			rate_index <= t.rate;
			attempt_count <= t.att;
			report_success <= t.succ;
			last_entry <= t.last;
		end
	end

	// acceptance: predict the result of each accepted transaction
	always @(posedge clk) begin
		stim_t t;
		if (arst_n && start && !busy && !taken) begin
			taken = 1'b1;
			t = '{mode_t'(mode), station_addr, entry_valid, rate_index, attempt_count,
				report_success, last_entry, 1'b0, 0};
			expected_q.push_back(predict_stats(t));
		end
	end

	// monitor: compare each strobed result with the oldest prediction
	always @(posedge clk) begin
		stats_res_t e;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$error("result with no transaction pending");
				failed = 1'b1;
			end else begin
				e = expected_q.pop_front();
				if (status !== e.st) begin
					$error("status expected %0d got %0d", e.st, status);
					failed = 1'b1;
				end
				if (peer_slot !== e.slot) begin
					$error("peer_slot expected %0d got %0d", e.slot, peer_slot);
					failed = 1'b1;
				end
				if (attempts_total !== e.att) begin
					$error("attempts_total expected %0d got %0d", e.att, attempts_total);
					failed = 1'b1;
				end
				if (success_total !== e.suc) begin
					$error("success_total expected %0d got %0d", e.suc, success_total);
					failed = 1'b1;
				end
				if (updated_peers !== e.upd) begin
					$error("updated_peers expected %0d got %0d", e.upd, updated_peers);
					failed = 1'b1;
				end
			end
		end
	end

	// timeout
	initial begin
		#4000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// stimulus and end of run
	initial begin
		int n;
		int p;
		int len;
		int sel;
		logic [47:0] a;
		logic [6:0] rt;
		failed = 1'b0;
		for (int k = 0; k < MaxPeers; k++) begin
			sb_addr[k] = '0;
			sb_in_use[k] = 0;
			sb_has_upd[k] = 0;
		end
		for (int k = 0; k < Cells; k++) begin
			sb_rate_valid[k] = 0;
			sb_att[k] = '0;
			sb_suc[k] = '0;
		end
		sb_last_rate = '0;
		sb_last_known = 0;
		sb_ended = 0;
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		for (int k = 2; k < PoolSize; k++)
			addr_pool[k] = 48'({$urandom, $urandom});

		// directed part
		cur_idle = 0;
		add_item(MODE_STATUS, addr_pool[0], 1'b1, 7'd0, 8'd5, 1'b1, 1'b1);   // unknown peer
		add_item(MODE_REMOVE, addr_pool[1], 1'b0, 7'd0, 8'd0, 1'b0, 1'b0);   // remove unknown
		for (int k = 0; k < MaxPeers; k++)
			add_item(MODE_ADD, addr_pool[k], 1'b0, 7'd0, 8'd0, 1'b0, 1'b0);
		add_item(MODE_ADD, addr_pool[MaxPeers], 1'b0, 7'd0, 8'd0, 1'b0, 1'b0); // table full
		add_item(MODE_ADD, addr_pool[1], 1'b0, 7'd0, 8'd0, 1'b0, 1'b0);        // present
		// report: extremes, invalid marker, ignored entry, success on last rate
		add_item(MODE_STATUS, addr_pool[1], 1'b1, 7'd127, 8'd255, 1'b0, 1'b0);
		add_item(MODE_STATUS, addr_pool[1], 1'b1, 7'd0, 8'd0, 1'b0, 1'b0);
		add_item(MODE_STATUS, addr_pool[1], 1'b0, 7'd5, 8'd9, 1'b0, 1'b0);
		add_item(MODE_STATUS, addr_pool[1], 1'b1, 7'd3, 8'd7, 1'b1, 1'b1);
		// report whose peer changes midway
		add_item(MODE_STATUS, addr_pool[0], 1'b1, 7'd127, 8'd255, 1'b0, 1'b0);
		add_item(MODE_STATUS, addr_pool[2], 1'b1, 7'd127, 8'd1, 1'b1, 1'b1);
		// success with no valid rate
		add_item(MODE_STATUS, addr_pool[3], 1'b0, 7'd0, 8'd0, 1'b1, 1'b1);
		add_item(MODE_TICK, '0, 1'b0, 7'd0, 8'd0, 1'b0, 1'b0);
		add_item(MODE_TICK, '1, 1'b1, 7'd127, 8'd255, 1'b1, 1'b1);
		add_item(MODE_REMOVE, addr_pool[1], 1'b0, 7'd0, 8'd0, 1'b0, 1'b0);
		add_item(MODE_ADD, addr_pool[1], 1'b0, 7'd0, 8'd0, 1'b0, 1'b0);       // counters cleared
		add_item(MODE_STATUS, addr_pool[1], 1'b1, 7'd127, 8'd2, 1'b1, 1'b1);

		// random part: mostly well-formed reports among churning peers
		n = 0;
		while (n < NumItems) begin
			cur_idle = (n < NumItems / 3) ? 27 : (n < 2 * NumItems / 3) ? 66 : 0;
			if (n == 600 || n == 1200)
				add_drain();
			sel = $urandom_range(99);
			p = $urandom_range(PoolSize - 1);
			a = addr_pool[p];
			if (sel < 9) begin
				add_item(MODE_ADD, a, 1'($urandom), 7'($urandom), 8'($urandom),
					1'($urandom), 1'($urandom));
				n++;
			end else if (sel < 14) begin
				add_item(MODE_REMOVE, a, 1'($urandom), 7'($urandom), 8'($urandom),
					1'($urandom), 1'($urandom));
				n++;
			end else if (sel < 19) begin
				add_item(MODE_TICK, 48'({$urandom, $urandom}), 1'($urandom), 7'($urandom),
					8'($urandom), 1'($urandom), 1'($urandom));
				n++;
			end else if (sel < 92) begin
				len = $urandom_range(4, 1);
				for (int k = 0; k < len; k++) begin
					rt = ($urandom_range(1) != 0) ? 7'($urandom_range(3)) : 7'($urandom);
					add_item(MODE_STATUS, a, ($urandom_range(9) != 0), rt, 8'($urandom),
						1'($urandom), (k == len - 1));
					n++;
				end
			end else begin
				add_item(mode_t'($urandom_range(3)), 48'({$urandom, $urandom}),
					1'($urandom), 7'($urandom), 8'($urandom), 1'($urandom),
					1'($urandom));
				n++;
			end
		end

		@(posedge arst_n);
		wait (pending_q.size() == 0 && (!start || taken) && expected_q.size() == 0);
		repeat (6) @(posedge clk);
		if (!failed && expected_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule : tx_rate_stats_table_top_tb
`default_nettype wire

@@ files.f @@
hw/rtl/trst_pkg.sv
hw/rtl/trst_ram.sv
hw/rtl/trst_ctrl.sv
hw/rtl/trst_dp.sv
hw/rtl/tx_rate_stats_table_top.sv
hw/rtl/trst_checker.sv
tb/sv/tx_rate_stats_table_top_tb.sv
